>>> src/section_latency_window_averager_defines.svh
// ----------------------------------------------------------------------------
// Section latency window averager: assertion macros
// Shared concurrent assertion forms, clocked on clk and idle during rst.
// ----------------------------------------------------------------------------
`ifndef SECTION_LATENCY_WINDOW_AVERAGER_DEFINES_SVH
`define SECTION_LATENCY_WINDOW_AVERAGER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLWA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SLWA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/slwa_pkg.sv
// ----------------------------------------------------------------------------
// Section latency window averager package
// Sizes, opcodes, state encoding and the structs shared between modules.
// ----------------------------------------------------------------------------
package slwa_pkg;

  localparam int SECTIONS     = 16;
  localparam int WINDOW_DEPTH = 16;
  localparam int TIME_BITS    = 32;

  // Fixed field widths of the stream items and the register
  localparam int OPCODE_W  = 2;
  localparam int SECTION_W = 4;
  localparam int STAMP_W   = 32;
  localparam int MEAN_W    = 32;
  localparam int WLEN_W    = 5;

  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 32;

  localparam int SEC_BITS   = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int HEAD_BITS  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int COUNT_BITS = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_BITS   = TIME_BITS + $clog2(WINDOW_DEPTH);

  localparam int SEC_DEPTH  = 2 ** SEC_BITS;
  localparam int RING_DEPTH = 2 ** (SEC_BITS + HEAD_BITS);

  localparam logic [SECTION_W:0] SEC_LIMIT = (SECTION_W + 1)'(SECTIONS);
  localparam logic [WLEN_W-1:0]  WLEN_RESET = WLEN_W'(16);

  localparam logic [OPCODE_W-1:0] OP_START = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_END   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EVICT,
    ST_DIV,
    ST_RESPOND
  } state_t;

  // One entry of the per-section memory
  typedef struct packed {
    logic [TIME_BITS-1:0]  start_stamp;
    logic [COUNT_BITS-1:0] fill;
    logic [HEAD_BITS-1:0]  head;
    logic [SUM_BITS-1:0]   sum;
  } sec_entry_t;

  typedef struct packed {
    logic                  start;
    logic [SUM_BITS-1:0]   dividend;
    logic [COUNT_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [SUM_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

>>> src/section_latency_window_averager.sv
// ----------------------------------------------------------------------------
// Section latency window averager
// Per-section start/end timing with a sliding-window mean of the durations.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one command per transfer: the opcode on s_tuser, section and
//   timestamp on s_tdata. Every command returns exactly one m_* transfer with
//   ok on m_tuser and mean_ticks on m_tdata (zero except for a good query).
//   window_len_we writes window_len, to be used while the block is idle (the
//   block does not enforce this); the write clears every window (counts,
//   heads, sums) but keeps open sections. Sequence:
//   One command at a time. Start, refused or empty commands go from lookup
//   to respond; an end command passes lookup, evict and respond (section
//   memory read, ring read, write back); a query waits in the divide state
//   on the serial divider that produces one quotient bit per cycle. s_tready
//   rises again together with m_tvalid, as the result enters the output register.
// Reset:
//   rst closes all sections, empties all windows and sets window_len 16.
//   No memory sweep is needed: per-section valid bits mask stale entries.
// Stall:
//   The result waits in the output register; a finished command holds in
//   its respond state until m_tready frees that register.
// ----------------------------------------------------------------------------
module section_latency_window_averager (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             window_len_we,
  input  logic [slwa_pkg::WLEN_W-1:0]      window_len_wdata,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [3:0] section, [35:4] timestamp, [39:36] zero
  input  logic [slwa_pkg::S_TDATA_W-1:0]   s_tdata,
  // [1:0] opcode
  input  logic [slwa_pkg::OPCODE_W-1:0]    s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [31:0] mean_ticks
  output logic [slwa_pkg::M_TDATA_W-1:0]   m_tdata,
  // [0] ok
  output logic                             m_tuser
);
  import slwa_pkg::*;

  `include "section_latency_window_averager_defines.svh"

  // Clamp a written window length into 1 .. WINDOW_DEPTH
  function automatic logic [COUNT_BITS-1:0] clamp_len(input logic [WLEN_W-1:0] v);
    logic [COUNT_BITS-1:0] r;
    if (v == '0) begin
      r = COUNT_BITS'(1);
    end else if (32'(v) > WINDOW_DEPTH) begin
      r = COUNT_BITS'(WINDOW_DEPTH);
    end else begin
      r = COUNT_BITS'(v);
    end
    return r;
  endfunction

  // Input field views
  logic [OPCODE_W-1:0]  in_opcode;
  logic [SECTION_W-1:0] in_section;
  logic [STAMP_W-1:0]   in_stamp;

  assign in_opcode  = s_tuser;
  assign in_section = s_tdata[SECTION_W-1:0];
  assign in_stamp   = s_tdata[SECTION_W +: STAMP_W];

  // Control and held item
  state_t                state, state_next;
  logic [COUNT_BITS-1:0] eff_len;
  logic [SECTIONS-1:0]   open_flag;
  logic [SECTIONS-1:0]   meta_valid;

  logic [OPCODE_W-1:0]   op_q;
  logic [SEC_BITS-1:0]   sec_q;
  logic                  sec_ok_q;
  logic [TIME_BITS-1:0]  stamp_q;

  // Context of an end command carried from lookup into the evict step
  sec_entry_t            ent_q;
  logic [HEAD_BITS-1:0]  head_q;
  logic                  full_q;
  logic [TIME_BITS-1:0]  dur_q;

  logic                  res_ok, res_ok_next;
  logic [MEAN_W-1:0]     res_mean, res_mean_next;
  logic                  res_load;

  // Memory ports
  logic                  sec_we;
  logic [SEC_BITS-1:0]   sec_raddr;
  sec_entry_t            sec_wdata;
  sec_entry_t            sec_rdata;

  logic                          ring_we;
  logic [SEC_BITS+HEAD_BITS-1:0] ring_raddr;
  logic [TIME_BITS-1:0]          ring_rdata;

  div_req_t              div_req;
  div_rsp_t              div_rsp;

  // Lookup view: meta fields of a cleared window read as zero
  sec_entry_t            lk_ent;
  logic [HEAD_BITS-1:0]  lk_head;
  logic                  lk_full;
  logic [COUNT_BITS-1:0] head_inc;

  logic                  open_set;
  logic                  open_clr;
  logic                  meta_set;
  logic                  capture;

  slwa_ram #(
    .WIDTH ($bits(sec_entry_t)),
    .DEPTH (SEC_DEPTH)
  ) u_sec_ram (
    .clk   (clk),
    .we    (sec_we),
    .waddr (sec_q),
    .wdata (sec_wdata),
    .raddr (sec_raddr),
    .rdata (sec_rdata)
  );

  slwa_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (RING_DEPTH)
  ) u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr ({sec_q, head_q}),
    .wdata (dur_q),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  slwa_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    lk_ent.start_stamp = sec_rdata.start_stamp;
    if (meta_valid[sec_q]) begin
      lk_ent.fill = sec_rdata.fill;
      lk_ent.head = sec_rdata.head;
      lk_ent.sum  = sec_rdata.sum;
    end else begin
      lk_ent.fill = '0;
      lk_ent.head = '0;
      lk_ent.sum  = '0;
    end
    // A head left beyond a shrunk window restarts at slot zero
    lk_head  = (COUNT_BITS'(lk_ent.head) >= eff_len) ? '0 : lk_ent.head;
    lk_full  = (lk_ent.fill >= eff_len);
    head_inc = COUNT_BITS'(head_q) + COUNT_BITS'(1);
  end

  // Next state, memory accesses and result selection
  always_comb begin
    state_next    = state;
    s_tready      = 1'b0;
    sec_raddr     = in_section[SEC_BITS-1:0];
    sec_we        = 1'b0;
    sec_wdata     = lk_ent;
    ring_we       = 1'b0;
    ring_raddr    = {sec_q, lk_head};
    div_req.start    = 1'b0;
    div_req.dividend = lk_ent.sum;
    div_req.divisor  = lk_ent.fill;
    open_set      = 1'b0;
    open_clr      = 1'b0;
    meta_set      = 1'b0;
    capture       = 1'b0;
    res_load      = 1'b0;
    res_ok_next   = 1'b0;
    res_mean_next = '0;

    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = ST_LOOKUP;
        end
      end

      ST_LOOKUP: begin
        state_next = ST_RESPOND;
        res_load   = 1'b1;
        if (sec_ok_q) begin
          case (op_q)
            OP_START: begin
              if (!open_flag[sec_q]) begin
                sec_we                = 1'b1;
                sec_wdata.start_stamp = stamp_q;
                open_set              = 1'b1;
                meta_set              = 1'b1;
                res_ok_next           = 1'b1;
              end
            end
            OP_END: begin
              if (open_flag[sec_q]) begin
                capture    = 1'b1;
                res_load   = 1'b0;
                state_next = ST_EVICT;
              end
            end
            OP_QUERY: begin
              if (lk_ent.fill != '0) begin
                div_req.start = 1'b1;
                res_load      = 1'b0;
                state_next    = ST_DIV;
              end
            end
            default: begin
              res_ok_next = 1'b0;
            end
          endcase
        end
      end

      ST_EVICT: begin
        // Drop the oldest duration when full, then push the new one
        sec_we      = 1'b1;
        ring_we     = 1'b1;
        open_clr    = 1'b1;
        meta_set    = 1'b1;
        sec_wdata   = ent_q;
        if (full_q) begin
          sec_wdata.sum = ent_q.sum - SUM_BITS'(ring_rdata) + SUM_BITS'(dur_q);
        end else begin
          sec_wdata.fill = ent_q.fill + COUNT_BITS'(1);
          sec_wdata.sum  = ent_q.sum + SUM_BITS'(dur_q);
        end
        sec_wdata.head = (head_inc >= eff_len) ? '0 : head_inc[HEAD_BITS-1:0];
        res_load    = 1'b1;
        res_ok_next = 1'b1;
        state_next  = ST_RESPOND;
      end

      ST_DIV: begin
        if (div_rsp.done) begin
          res_load      = 1'b1;
          res_ok_next   = 1'b1;
          res_mean_next = div_rsp.quotient[MEAN_W-1:0];
          state_next    = ST_RESPOND;
        end
      end

      ST_RESPOND: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Section flags and window length
  always_ff @(posedge clk) begin
    if (rst) begin
      open_flag  <= '0;
      meta_valid <= '0;
      eff_len    <= clamp_len(WLEN_RESET);
    end else begin
      if (open_set) begin
        open_flag[sec_q] <= 1'b1;
      end else if (open_clr) begin
        open_flag[sec_q] <= 1'b0;
      end
      if (window_len_we) begin
        meta_valid <= '0;
        eff_len    <= clamp_len(window_len_wdata);
      end else if (meta_set) begin
        meta_valid[sec_q] <= 1'b1;
      end
    end
  end

  // Hold the accepted item and the end-command context
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_q     <= in_opcode;
      sec_q    <= in_section[SEC_BITS-1:0];
      sec_ok_q <= ({1'b0, in_section} < SEC_LIMIT);
      stamp_q  <= in_stamp[TIME_BITS-1:0];
    end
    if (capture) begin
      ent_q  <= lk_ent;
      head_q <= lk_head;
      full_q <= lk_full;
      dur_q  <= stamp_q - lk_ent.start_stamp;
    end
    if (res_load) begin
      res_ok   <= res_ok_next;
      res_mean <= res_mean_next;
    end
  end

  // Output register: load in the respond state when empty or when the current transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_RESPOND) && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_RESPOND) && (!m_tvalid || m_tready)) begin
      m_tdata <= res_mean;
      m_tuser <= res_ok;
    end
  end

  `SLWA_ASSERT_NEXT(a_accept_lookup, s_tvalid && s_tready, state == ST_LOOKUP,
    "accepted command did not enter lookup")
  `SLWA_ASSERT_SAME(a_sec_write_phase, sec_we,
    (state == ST_LOOKUP) || (state == ST_EVICT), "section write outside update")
  `SLWA_ASSERT_SAME(a_fill_bound, sec_we, sec_wdata.fill <= eff_len,
    "window fill exceeds window length")
  `SLWA_ASSERT_SAME(a_ring_open, ring_we, open_flag[sec_q],
    "duration pushed for a closed section")

endmodule

>>> src/slwa_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module slwa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/slwa_divider.sv
// ----------------------------------------------------------------------------
// Serial restoring divider
// Divides the window sum by the fill count, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module slwa_divider (
  input  logic                clk,
  input  logic                rst,
  input  slwa_pkg::div_req_t  req,
  output slwa_pkg::div_rsp_t  rsp
);
  import slwa_pkg::*;

  `include "section_latency_window_averager_defines.svh"

  localparam int CNT_W = $clog2(SUM_BITS + 1);

  logic                  busy;
  logic                  done;
  logic [CNT_W-1:0]      count;
  logic [SUM_BITS-1:0]   quot;
  logic [COUNT_BITS:0]   rem;
  logic [COUNT_BITS-1:0] divisor;

  logic [COUNT_BITS:0]   rem_sh;
  logic [COUNT_BITS:0]   diff;
  logic                  take;

  // Shift the next dividend bit into the partial remainder, subtract if it fits
  always_comb begin
    rem_sh = {rem[COUNT_BITS-1:0], quot[SUM_BITS-1]};
    diff   = rem_sh - {1'b0, divisor};
    take   = (rem_sh >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (count == CNT_W'(1))) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quot    <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
      count   <= CNT_W'(SUM_BITS);
    end else if (busy) begin
      quot  <= {quot[SUM_BITS-2:0], take};
      rem   <= take ? diff : rem_sh;
      count <= count - CNT_W'(1);
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quot;

  `SLWA_ASSERT_NEXT(a_div_start_busy, req.start, busy, "divider did not start")
  `SLWA_ASSERT_SAME(a_div_start_idle, req.start, !busy, "divider restarted while busy")
  `SLWA_ASSERT_SAME(a_div_done_idle, done, !busy, "divider done while still busy")

endmodule
